>>> sv/lrbg_pkg.sv
// ----------------------------------------------------------------------------
// lrbg_pkg
// Shared types and constants of the local range and bearing gate.
// ----------------------------------------------------------------------------
package lrbg_pkg;

  localparam int unsigned STAGE_MAX = 24;
  localparam int unsigned CW        = 41;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [29:0] DEG_Q32      = 30'd764985215;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [23:0] RANGE_MAX    = 24'hFFFFFF;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] BEARING_RND  = 32'h0000_8000;

  localparam logic [16:0] COS_SCALE_RST   = 17'd65536;
  localparam logic [23:0] RANGE_LIMIT_RST = 24'd16000;

  localparam logic [31:0] ATAN_TURNS [STAGE_MAX] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CTR_LAT     = 4'd0,
    CFG_CTR_LON     = 4'd1,
    CFG_COS_SCALE   = 4'd2,
    CFG_RANGE_LIMIT = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [30:0] target_lat;
    logic signed [31:0] target_lon;
    logic               target_active;
  } in_item_t;

  typedef struct packed {
    logic [23:0] range_out;
    logic [15:0] bearing_out;
    logic        detected;
  } out_item_t;

  typedef struct packed {
    logic signed [30:0] ctr_lat;
    logic signed [31:0] ctr_lon;
    logic [16:0]        cos_scale;
    logic [23:0]        range_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
    logic                 active;
  } cordic_t;

endpackage

>>> sv/lrbg_scale.sv
// ----------------------------------------------------------------------------
// lrbg_scale
// Front end: offsets from the centre, degree to metre scaling, cosine scaling
// and the start vector of the cordic chain, in five pipeline stages.
// ----------------------------------------------------------------------------
module lrbg_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrbg_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  lrbg_pkg::in_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lrbg_pkg::cordic_t  item_o
);
  import lrbg_pkg::*;

  localparam int unsigned NS = 5;
  localparam logic [63:0] RND24 = 64'd1 << 23;
  localparam logic [54:0] RND16 = 55'd1 << 15;

  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;
  logic [NS-1:0] v_in;

  assign v_in    = {v_q[NS-2:0], valid_i};
  assign ready_o = rdy[0];
  assign valid_o = v_q[NS-1];

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // stage 0: offsets and magnitudes
  logic [31:0] dlat, mlat;
  logic [32:0] dlon, mlon;
  logic [31:0] s0_mlat_q;
  logic [32:0] s0_mlon_q;
  logic        s0_slat_q, s0_slon_q, s0_act_q;

  assign dlat = {item_i.target_lat[30], item_i.target_lat}
              - {cfg_i.ctr_lat[30], cfg_i.ctr_lat};
  assign dlon = {item_i.target_lon[31], item_i.target_lon}
              - {cfg_i.ctr_lon[31], cfg_i.ctr_lon};
  assign mlat = dlat[31] ? (32'd0 - dlat) : dlat;
  assign mlon = dlon[32] ? (33'd0 - dlon) : dlon;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && v_in[0]) begin
      s0_mlat_q <= mlat;
      s0_mlon_q <= mlon;
      s0_slat_q <= dlat[31];
      s0_slon_q <= dlon[32];
      s0_act_q  <= item_i.target_active;
    end
  end

  // stage 1: partial products with the degree factor
  logic [45:0] s1_plat_lo_q, s1_plat_hi_q, s1_plon_lo_q;
  logic [46:0] s1_plon_hi_q;
  logic        s1_slat_q, s1_slon_q, s1_act_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_in[1]) begin
      s1_plat_lo_q <= 46'(s0_mlat_q[15:0]) * 46'(DEG_Q32);
      s1_plat_hi_q <= 46'(s0_mlat_q[31:16]) * 46'(DEG_Q32);
      s1_plon_lo_q <= 46'(s0_mlon_q[15:0]) * 46'(DEG_Q32);
      s1_plon_hi_q <= 47'(s0_mlon_q[32:16]) * 47'(DEG_Q32);
      s1_slat_q    <= s0_slat_q;
      s1_slon_q    <= s0_slon_q;
      s1_act_q     <= s0_act_q;
    end
  end

  // stage 2: sum and round to 4096ths of a metre
  logic [63:0] nsum, esum;
  logic [36:0] s2_nm_q;
  logic [37:0] s2_em_q;
  logic        s2_slat_q, s2_slon_q, s2_act_q;

  assign nsum = {2'd0, s1_plat_hi_q, 16'd0} + {18'd0, s1_plat_lo_q} + RND24;
  assign esum = {1'd0, s1_plon_hi_q, 16'd0} + {18'd0, s1_plon_lo_q} + RND24;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_in[2]) begin
      s2_nm_q   <= nsum[60:24];
      s2_em_q   <= esum[61:24];
      s2_slat_q <= s1_slat_q;
      s2_slon_q <= s1_slon_q;
      s2_act_q  <= s1_act_q;
    end
  end

  // stage 3: cosine scaling of east
  logic [54:0] s3_eprod_q;
  logic [36:0] s3_nm_q;
  logic        s3_slat_q, s3_slon_q, s3_act_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_in[3]) begin
      s3_eprod_q <= 55'(s2_em_q) * 55'(cfg_i.cos_scale);
      s3_nm_q    <= s2_nm_q;
      s3_slat_q  <= s2_slat_q;
      s3_slon_q  <= s2_slon_q;
      s3_act_q   <= s2_act_q;
    end
  end

  // stage 4: signed offsets and start vector
  logic [54:0]          esum2;
  logic [38:0]          em2;
  logic signed [CW-1:0] emag, east_s;
  logic                 neg_half;
  cordic_t              start, s4_q;

  assign esum2    = s3_eprod_q + RND16;
  assign em2      = esum2[54:16];
  assign emag     = {2'd0, em2};
  assign east_s   = s3_slon_q ? -emag : emag;
  assign neg_half = s3_slat_q && (s3_nm_q != '0);

  always_comb begin
    start.x      = {4'd0, s3_nm_q};
    start.y      = neg_half ? -east_s : east_s;
    start.z      = neg_half ? HALF_TURN : '0;
    start.zero   = (s3_nm_q == '0) && (em2 == '0);
    start.active = s3_act_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_in[4]) begin
      s4_q <= start;
    end
  end

  assign item_o = s4_q;

endmodule

>>> sv/lrbg_cordic_cell.sv
// ----------------------------------------------------------------------------
// lrbg_cordic_cell
// One vectoring step of the cordic chain with its own pipeline register.
// ----------------------------------------------------------------------------
module lrbg_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  lrbg_pkg::cordic_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lrbg_pkg::cordic_t item_o
);
  import lrbg_pkg::*;

  logic signed [CW-1:0] x, y, xs, ys;
  cordic_t              nxt, item_q;
  logic                 valid_q;

  assign x  = item_i.x;
  assign y  = item_i.y;
  assign xs = x >>> STAGE;
  assign ys = y >>> STAGE;

  always_comb begin
    nxt = item_i;
    if (!y[CW-1]) begin
      nxt.x = x + ys;
      nxt.y = y - xs;
      nxt.z = item_i.z + ATAN_TURNS[STAGE];
    end else begin
      nxt.x = x - ys;
      nxt.y = y + xs;
      nxt.z = item_i.z - ATAN_TURNS[STAGE];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= nxt;
    end
  end

endmodule

>>> sv/local_range_bearing_gate.sv
// ----------------------------------------------------------------------------
// local_range_bearing_gate
// Flat-earth range and bearing of one target position from a configured
// centre, with a detection gate on range.
//
//   channel  signals                                  moves
//   in       in_valid_i  in_ready_o  in_item_i        target position
//   out      out_valid_o out_ready_i out_item_o       range, bearing, detected
//   cfg      cfg_valid_i cfg_ready_o cfg_index_i/data register write
//
// one item per cycle while out_ready_i does not stall; pipeline (24 cells at most):
// five scaling stages, one cell per cordic step, two output stages
// every stage collapses bubbles, so an item enters while a result waits
// reset clears all valid bits and loads the register reset values
// cfg writes always complete: cfg_ready_o is high in every cycle
// ----------------------------------------------------------------------------
module local_range_bearing_gate #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lrbg_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lrbg_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lrbg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lrbg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lrbg_pkg::*;

  localparam int unsigned NUM_CELLS =
    (CORDIC_STAGES > STAGE_MAX) ? STAGE_MAX : CORDIC_STAGES;
  localparam logic [56:0] RND24 = 57'd1 << 23;

  // configuration registers
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ctr_lat     <= '0;
      cfg_q.ctr_lon     <= '0;
      cfg_q.cos_scale   <= COS_SCALE_RST;
      cfg_q.range_limit <= RANGE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CTR_LAT:     cfg_q.ctr_lat     <= cfg_data_i[30:0];
        CFG_CTR_LON:     cfg_q.ctr_lon     <= cfg_data_i;
        CFG_COS_SCALE:   cfg_q.cos_scale   <= cfg_data_i[16:0];
        CFG_RANGE_LIMIT: cfg_q.range_limit <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // cordic chain
  logic    c_valid [NUM_CELLS+1];
  logic    c_ready [NUM_CELLS+1];
  cordic_t c_item  [NUM_CELLS+1];

  lrbg_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .valid_o (c_valid[0]),
    .ready_i (c_ready[0]),
    .item_o  (c_item[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    lrbg_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k]),
      .ready_o (c_ready[k]),
      .item_i  (c_item[k]),
      .valid_o (c_valid[k+1]),
      .ready_i (c_ready[k+1]),
      .item_o  (c_item[k+1])
    );
  end

  // output stages: gain correction, rounding, saturation, gate
  logic        b0_valid_q, b1_valid_q, b0_rdy, b1_rdy;
  logic [39:0] xmag;
  logic [55:0] b0_prod_q;
  logic [31:0] b0_z_q;
  logic        b0_zero_q, b0_act_q;
  logic [56:0] rsum;
  logic [32:0] rng;
  logic        sat;
  logic [31:0] brnd;
  out_item_t   res, out_q;

  assign b1_rdy = !b1_valid_q || out_ready_i;
  assign b0_rdy = !b0_valid_q || b1_rdy;
  assign c_ready[NUM_CELLS] = b0_rdy;

  assign xmag = c_item[NUM_CELLS].x[CW-1] ? 40'(-c_item[NUM_CELLS].x)
                                          : 40'(c_item[NUM_CELLS].x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_valid_q <= 1'b0;
      b1_valid_q <= 1'b0;
    end else begin
      if (b0_rdy) begin
        b0_valid_q <= c_valid[NUM_CELLS];
      end
      if (b1_rdy) begin
        b1_valid_q <= b0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b0_rdy && c_valid[NUM_CELLS]) begin
      b0_prod_q <= 56'(xmag) * 56'(INV_GAIN_Q16);
      b0_z_q    <= c_item[NUM_CELLS].z;
      b0_zero_q <= c_item[NUM_CELLS].zero;
      b0_act_q  <= c_item[NUM_CELLS].active;
    end
  end

  assign rsum = {1'b0, b0_prod_q} + RND24;
  assign rng  = b0_zero_q ? '0 : rsum[56:24];
  assign sat  = rng > {9'd0, RANGE_MAX};
  assign brnd = b0_z_q + BEARING_RND;

  always_comb begin
    res.range_out   = sat ? RANGE_MAX : rng[23:0];
    res.bearing_out = b0_zero_q ? '0 : brnd[31:16];
    res.detected    = b0_act_q && !sat && (rng[23:0] <= cfg_q.range_limit);
  end

  always_ff @(posedge clk_i) begin
    if (b1_rdy && b0_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = b1_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/lrbg_checker.sv
// ----------------------------------------------------------------------------
// lrbg_sva
// Port-level checks of the local range and bearing gate, bound to the top.
// ----------------------------------------------------------------------------
module lrbg_sva (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input lrbg_pkg::in_item_t              in_item_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input lrbg_pkg::out_item_t             out_item_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  // a free output stage means the whole chain can move
  a_in_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output side can move");

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_item_i))
    else $error("input item unknown while valid");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_item_o))
    else $error("output item unknown while valid");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("cfg write not taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output item changed");

endmodule

bind local_range_bearing_gate lrbg_sva u_lrbg_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

>>> tb/lrbg_checker.sv
// ----------------------------------------------------------------------------
// lrbg_checker
// Watches the target, result and register channels of the range and bearing
// gate. Every accepted target is run through a flat-earth offset and CORDIC
// vectoring predictor with a local copy of the registers; every accepted
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lrbg_checker #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  lrbg_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  lrbg_pkg::out_item_t             out_item_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lrbg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lrbg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lrbg_pkg::*;

  localparam int unsigned N_STAGES = (CORDIC_STAGES > STAGE_MAX) ? STAGE_MAX : CORDIC_STAGES;

  cfg_t        gate_cfg;
  out_item_t   expected_reports[$];
  out_item_t   want;
  int unsigned mismatch_cnt = 0;

  function automatic out_item_t predict_range_bearing(input in_item_t tgt, input cfg_t c);
    longint      dlat, dlon, north, east, x, y, nx;
    bit [63:0]   nmag, emag, rng;
    bit [31:0]   z;
    bit [15:0]   brg;
    bit          sat;
    int unsigned i;
    out_item_t   res;
    dlat = longint'($signed(tgt.target_lat)) - longint'($signed(c.ctr_lat));
    dlon = longint'($signed(tgt.target_lon)) - longint'($signed(c.ctr_lon));
    nmag = ((dlat < 0 ? 64'(-dlat) : 64'(dlat)) * 64'(DEG_Q32) + (64'd1 << 23)) >> 24;
    emag = ((dlon < 0 ? 64'(-dlon) : 64'(dlon)) * 64'(DEG_Q32) + (64'd1 << 23)) >> 24;
    emag = (emag * 64'(c.cos_scale) + (64'd1 << 15)) >> 16;
    north = dlat < 0 ? -longint'(nmag) : longint'(nmag);
    east  = dlon < 0 ? -longint'(emag) : longint'(emag);
    sat = 1'b0;
    if (north == 0 && east == 0) begin
      rng = '0;
      brg = '0;
    end else begin
      // southern half starts from a half turn
      if (north < 0) begin
        x = -north;
        y = -east;
        z = HALF_TURN;
      end else begin
        x = north;
        y = east;
        z = '0;
      end
      for (i = 0; i < N_STAGES; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + ATAN_TURNS[i];
        end else begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - ATAN_TURNS[i];
        end
        x = nx;
      end
      rng = ((x < 0 ? 64'(-x) : 64'(x)) * 64'(INV_GAIN_Q16) + (64'd1 << 23)) >> 24;
      brg = 16'((z + BEARING_RND) >> 16);
    end
    if (rng > 64'(RANGE_MAX)) begin
      rng = 64'(RANGE_MAX);
      sat = 1'b1;
    end
    res.range_out   = rng[23:0];
    res.bearing_out = brg;
    res.detected    = tgt.target_active && !sat && (rng <= 64'(c.range_limit));
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      gate_cfg = '{ctr_lat: '0, ctr_lon: '0, cos_scale: COS_SCALE_RST,
                   range_limit: RANGE_LIMIT_RST};
      expected_reports.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result: range_out %0d bearing_out %0d detected %0b",
                 out_item_i.range_out, out_item_i.bearing_out, out_item_i.detected);
          mismatch_cnt++;
        end else begin
          want = expected_reports.pop_front();
          if (out_item_i.range_out !== want.range_out) begin
            $error("range_out: expected %0d, actual %0d", want.range_out,
                   out_item_i.range_out);
            mismatch_cnt++;
          end
          if (out_item_i.bearing_out !== want.bearing_out) begin
            $error("bearing_out: expected %0d, actual %0d", want.bearing_out,
                   out_item_i.bearing_out);
            mismatch_cnt++;
          end
          if (out_item_i.detected !== want.detected) begin
            $error("detected: expected %0b, actual %0b", want.detected,
                   out_item_i.detected);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_reports.insert(expected_reports.size(),
                                predict_range_bearing(in_item_i, gate_cfg));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CTR_LAT:     gate_cfg.ctr_lat     = cfg_data_i[30:0];
          CFG_CTR_LON:     gate_cfg.ctr_lon     = cfg_data_i[31:0];
          CFG_COS_SCALE:   gate_cfg.cos_scale   = cfg_data_i[16:0];
          CFG_RANGE_LIMIT: gate_cfg.range_limit = cfg_data_i[23:0];
          default: ;
        endcase
      end
    end
    errors_o  <= mismatch_cnt;
    pending_o <= unsigned'(expected_reports.size());
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the local range and bearing gate. Drives a short directed
// set of target positions, then random targets over several register
// settings and idling patterns, and leaves prediction and comparison to
// lrbg_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lrbg_pkg::*;

  localparam int unsigned CORDIC_STAGES   = 16;
  localparam int unsigned DRAIN_CYCLES    = 2 * (CORDIC_STAGES + 7);
  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 244;
  localparam int unsigned FIRST_SPARE_IDX = int'(CFG_RANGE_LIMIT) + 1;
  localparam int unsigned LAST_IDX        = 2 ** CFG_IDX_W - 1;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_item_t              in_item     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  int unsigned           fail_cnt;
  int unsigned           pending_cnt;
  int unsigned           cycle_cnt   = 0;
  int unsigned           send_gap_pct = 0;
  int unsigned           recv_stall_pct = 0;
  longint                cur_lat     = 0;
  longint                cur_lon     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  local_range_bearing_gate #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  lrbg_checker #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_item_i (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (fail_cnt),
    .pending_o  (pending_cnt)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("local_range_bearing_gate regression: fail");
      $finish;
    end
  end

  function automatic in_item_t mk_target(input longint lat, input longint lon, input bit act);
    in_item_t t;
    t.target_lat    = 31'(lat);
    t.target_lon    = 32'(lon);
    t.target_active = act;
    return t;
  endfunction

  function automatic longint near_offset();
    longint off;
    off = longint'($urandom_range(0, 1 << $urandom_range(0, 27)));
    return $urandom_range(0, 1) ? -off : off;
  endfunction

  function automatic in_item_t rand_target();
    int unsigned sel;
    bit          act;
    sel = $urandom_range(0, 99);
    act = ($urandom_range(0, 3) != 0);
    if (sel < 60) begin
      return mk_target(cur_lat + near_offset(), cur_lon + near_offset(), act);
    end else if (sel < 85) begin
      return mk_target(longint'($urandom_range(0, 1800000000)) - 900000000,
                       longint'($urandom_range(0, 3600000000)) - 1800000000, act);
    end
    return mk_target(longint'($urandom()), longint'($urandom()), act);
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    send_gap_pct   <= (mode == IDLE_SEND) ? 66 : (mode == IDLE_BOTH) ? 21 : 0;
    recv_stall_pct <= (mode == IDLE_RECV) ? 66 : (mode == IDLE_BOTH) ? 21 : 0;
  endtask

  task automatic push_target(input in_item_t tgt);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused upper data bits carry junk, the gate keeps only the register width
  task automatic program_gate(input longint lat, input longint lon,
                              input int unsigned cos_q16, input int unsigned limit);
    write_reg(CFG_CTR_LAT, {1'($urandom_range(0, 1)), 31'(lat)});
    write_reg(CFG_CTR_LON, 32'(lon));
    write_reg(CFG_COS_SCALE, {15'($urandom()), 17'(cos_q16)});
    write_reg(CFG_RANGE_LIMIT, {8'($urandom()), 24'(limit)});
    write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, LAST_IDX)), $urandom());
    cfg_valid <= 1'b0;
    cur_lat = longint'($signed(31'(lat)));
    cur_lon = longint'($signed(32'(lon)));
  endtask

  initial begin
    in_item_t    directed[$];
    int unsigned ph;
    int unsigned n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: centre at origin, full cosine, 1000 m limit
    directed = '{
      mk_target(0, 0, 1), mk_target(0, 0, 0),
      mk_target(89800, 0, 1), mk_target(89900, 0, 1), mk_target(89800, 0, 0),
      mk_target(-89800, 0, 1), mk_target(0, 89800, 1), mk_target(0, -89800, 1),
      mk_target(50000, 50000, 1), mk_target(-50000, -50000, 0),
      mk_target(900000000, 0, 1), mk_target(-900000000, 0, 1),
      mk_target(1073741823, 2147483647, 1), mk_target(-1073741824, -2147483648, 1),
      mk_target(0, 1800000000, 1), mk_target(0, -1800000000, 1),
      mk_target(1, 0, 1), mk_target(0, 1, 1), mk_target(-1, -1, 1),
      mk_target(0, -1, 1), mk_target(-1, 0, 1)
    };
    foreach (directed[k]) push_target(directed[k]);
    drain();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: program_gate(0, 0, 65536, 16000);
        1: program_gate(900000000, 1800000000, 0, 0);
        2: program_gate(-900000000, -1800000000, 65536, 16777215);
        3: program_gate(-1073741824, -2147483648, 131071, $urandom_range(0, 16777215));
        4: program_gate(1073741823, 2147483647, $urandom_range(0, 131071),
                        $urandom_range(0, 16777215));
        5: program_gate(longint'($urandom_range(0, 1800000000)) - 900000000,
                        longint'($urandom_range(0, 3600000000)) - 1800000000,
                        $urandom_range(0, 65536), $urandom_range(0, 1 << 18));
        default: program_gate(longint'($urandom_range(0, 1800000000)) - 900000000,
                              longint'($urandom_range(0, 3600000000)) - 1800000000,
                              $urandom_range(0, 65536), $urandom_range(0, 16777215));
      endcase
      set_idling(idle_mode_e'(ph % 4));
      for (n = 0; n < ITEMS_PER_PHASE; n++) push_target(rand_target());
      drain();
    end

    set_idling(IDLE_NONE);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("local_range_bearing_gate regression: pass");
    end else begin
      $display("local_range_bearing_gate regression: fail");
    end
    $finish;
  end

endmodule

>>> local_range_bearing_gate.f
sv/lrbg_pkg.sv
sv/lrbg_scale.sv
sv/lrbg_cordic_cell.sv
sv/local_range_bearing_gate.sv
sv/lrbg_checker.sv
tb/lrbg_checker.sv
tb/tb_top.sv
